// ----- src/fbc_pkg.sv -----
// Shared constants, types and command/status bundles for the frustum box cull block.
package fbc_pkg;

  localparam int NUM_PLANES  = 6;
  localparam int PLANE_IDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

  localparam int NORM_W  = 18;
  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = NORM_W + DIFF_W;
  localparam int FRAC_W  = 16;
  localparam int SUM_W   = PROD_W + 3;
  localparam int CFG_IDX_W = 2;
  localparam int SEL_W   = 3;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_TEST  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z = 2'd2;

  typedef logic signed [NORM_W-1:0]  norm_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  typedef struct packed {
    logic                   capture;
    logic                   write_plane;
    logic                   start;
    logic                   issue;
    logic [PLANE_IDX_W-1:0] plane_sel;
    logic                   load_out;
  } fbc_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_full;
  } fbc_status_t;

endpackage

// ----- src/fbc_ctrl.sv -----
// Controller: input handshake, plane sequencing, drain and result hand-off.
module fbc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                action,
  input  fbc_pkg::fbc_status_t status,
  output fbc_pkg::fbc_cmd_t    cmd
);
  import fbc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ISSUE  = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic [PLANE_IDX_W-1:0] plane_cnt;
  logic [PLANE_IDX_W-1:0] plane_cnt_next;
  logic                   accept;
  logic                   last_plane;

  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign last_plane = (plane_cnt == PLANE_IDX_W'(NUM_PLANES - 1));

  always_comb begin
    state_next     = state;
    plane_cnt_next = plane_cnt;
    cmd            = '0;
    cmd.plane_sel  = plane_cnt;
    case (state)
      ST_IDLE: begin
        cmd.capture = accept;
        if (accept) begin
          if (action == ACT_TEST) begin
            cmd.start      = 1'b1;
            plane_cnt_next = '0;
            state_next     = ST_ISSUE;
          end else begin
            cmd.write_plane = 1'b1;
          end
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (last_plane) begin
          state_next = ST_DRAIN;
        end else begin
          plane_cnt_next = plane_cnt + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!status.out_full) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      plane_cnt <= '0;
    end else begin
      state     <= state_next;
      plane_cnt <= plane_cnt_next;
    end
  end

endmodule

// ----- src/fbc_dp.sv -----
// Datapath: camera registers, plane table, three-stage plane evaluation, result register.
module fbc_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  fbc_pkg::fbc_cmd_t             cmd,
  output fbc_pkg::fbc_status_t          status,
  input  logic                          cfg_valid,
  input  logic [fbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic [fbc_pkg::SEL_W-1:0]     plane_index,
  input  logic signed [17:0]            normal_a,
  input  logic signed [17:0]            normal_b,
  input  logic signed [17:0]            normal_c,
  input  logic signed [31:0]            offset_d,
  input  logic signed [31:0]            box_min_x,
  input  logic signed [31:0]            box_min_y,
  input  logic signed [31:0]            box_min_z,
  input  logic signed [31:0]            box_max_x,
  input  logic signed [31:0]            box_max_y,
  input  logic signed [31:0]            box_max_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          visible
);
  import fbc_pkg::*;

  coord_t camera_x, camera_y, camera_z;
  coord_t lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;

  norm_t  tab_a [NUM_PLANES];
  norm_t  tab_b [NUM_PLANES];
  norm_t  tab_c [NUM_PLANES];
  coord_t tab_d [NUM_PLANES];

  norm_t  sel_a, sel_b, sel_c;
  coord_t pick_x, pick_y, pick_z;
  logic   idx_ok;

  // stage A: chosen corner relative to camera
  logic   a_valid;
  norm_t  a_na, a_nb, a_nc;
  diff_t  a_dx, a_dy, a_dz;
  coord_t a_d;

  // stage B: products
  logic   b_valid;
  prod_t  b_px, b_py, b_pz;
  coord_t b_d;

  sum_t   plane_sum;
  logic   verdict;

  assign idx_ok = ({1'b0, plane_index} < (SEL_W + 1)'(NUM_PLANES));

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x <= '0;
      camera_y <= '0;
      camera_z <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CAMERA_X: camera_x <= cfg_data;
        REG_CAMERA_Y: camera_y <= cfg_data;
        REG_CAMERA_Z: camera_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        tab_a[i] <= '0;
        tab_b[i] <= '0;
        tab_c[i] <= '0;
        tab_d[i] <= '0;
      end
    end else if (cmd.write_plane && idx_ok) begin
      tab_a[plane_index[PLANE_IDX_W-1:0]] <= normal_a;
      tab_b[plane_index[PLANE_IDX_W-1:0]] <= normal_b;
      tab_c[plane_index[PLANE_IDX_W-1:0]] <= normal_c;
      tab_d[plane_index[PLANE_IDX_W-1:0]] <= offset_d;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lo_x <= box_min_x;
      lo_y <= box_min_y;
      lo_z <= box_min_z;
      hi_x <= box_max_x;
      hi_y <= box_max_y;
      hi_z <= box_max_z;
    end
  end

  assign sel_a  = tab_a[cmd.plane_sel];
  assign sel_b  = tab_b[cmd.plane_sel];
  assign sel_c  = tab_c[cmd.plane_sel];
  assign pick_x = (sel_a > 0) ? hi_x : lo_x;
  assign pick_y = (sel_b > 0) ? hi_y : lo_y;
  assign pick_z = (sel_c > 0) ? hi_z : lo_z;

  always_ff @(posedge clk) begin
    a_na <= sel_a;
    a_nb <= sel_b;
    a_nc <= sel_c;
    a_dx <= DIFF_W'(pick_x) - DIFF_W'(camera_x);
    a_dy <= DIFF_W'(pick_y) - DIFF_W'(camera_y);
    a_dz <= DIFF_W'(pick_z) - DIFF_W'(camera_z);
    a_d  <= tab_d[cmd.plane_sel];
  end

  always_ff @(posedge clk) begin
    b_px <= PROD_W'(a_na) * PROD_W'(a_dx);
    b_py <= PROD_W'(a_nb) * PROD_W'(a_dy);
    b_pz <= PROD_W'(a_nc) * PROD_W'(a_dz);
    b_d  <= a_d;
  end

  assign plane_sum = SUM_W'(b_px) + SUM_W'(b_py) + SUM_W'(b_pz)
                   + sum_t'({{(SUM_W - COORD_W - FRAC_W){b_d[COORD_W-1]}}, b_d,
                             {FRAC_W{1'b0}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= cmd.issue;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      verdict <= 1'b1;
    end else if (b_valid && plane_sum[SUM_W-1]) begin
      verdict <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      visible <= verdict;
    end
  end

  assign status.pipe_busy = a_valid || b_valid;
  assign status.out_full  = out_valid && !out_ready;

endmodule

// ----- src/frustum_box_cull_top.sv -----
// Test beat: after acceptance each plane is issued in turn, the pipeline drains, then the result register loads.
// A new test is taken only once the last one is through; one plane per cycle through three multipliers.
// Plane write beats are taken every cycle while no test is in progress and give no result; config writes every cycle.
// The result register lets the next beat in while a verdict waits to be taken.
// Synchronous active-high reset clears control, camera registers and all planes,
// so every box reads as visible until planes are loaded.
module frustum_box_cull_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [2:0]                    plane_index,
  input  logic signed [17:0]            normal_a,
  input  logic signed [17:0]            normal_b,
  input  logic signed [17:0]            normal_c,
  input  logic signed [31:0]            offset_d,
  input  logic signed [31:0]            box_min_x,
  input  logic signed [31:0]            box_min_y,
  input  logic signed [31:0]            box_min_z,
  input  logic signed [31:0]            box_max_x,
  input  logic signed [31:0]            box_max_y,
  input  logic signed [31:0]            box_max_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          visible
);
  import fbc_pkg::*;

  fbc_cmd_t    cmd;
  fbc_status_t status;

  assign cfg_ready = 1'b1;

  fbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .status   (status),
    .cmd      (cmd)
  );

  fbc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .plane_index (plane_index),
    .normal_a    (normal_a),
    .normal_b    (normal_b),
    .normal_c    (normal_c),
    .offset_d    (offset_d),
    .box_min_x   (box_min_x),
    .box_min_y   (box_min_y),
    .box_min_z   (box_min_z),
    .box_max_x   (box_max_x),
    .box_max_y   (box_max_y),
    .box_max_z   (box_max_z),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .visible     (visible)
  );

endmodule

// ----- verif/tb_frustum_box_cull_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for frustum_box_cull_top: plane loads, box tests, camera settings.
module tb_frustum_box_cull_top;
  import fbc_pkg::*;

  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     DRAIN_CYCLES = 16;
  localparam int     MAX_WAIT     = 12;
  localparam int     PHASES       = 7;
  localparam int     PHASE_ITEMS  = 172;
  localparam coord_t CMIN         = 32'sh8000_0000;
  localparam coord_t CMAX         = 32'sh7fff_ffff;
  localparam norm_t  NMIN         = 18'sh2_0000;
  localparam norm_t  NMAX         = 18'sh1_ffff;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic       act;
    logic [2:0] idx;
    norm_t      na;
    norm_t      nb;
    norm_t      nc;
    coord_t     d;
    coord_t     min_x;
    coord_t     min_y;
    coord_t     min_z;
    coord_t     max_x;
    coord_t     max_y;
    coord_t     max_z;
  } cull_beat_t;

  logic                 clk;
  logic                 rst         = 1'b1;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [31:0]          cfg_data    = '0;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic                 action      = 1'b0;
  logic [2:0]           plane_index = '0;
  norm_t                normal_a    = '0;
  norm_t                normal_b    = '0;
  norm_t                normal_c    = '0;
  coord_t               offset_d    = '0;
  coord_t               box_min_x   = '0;
  coord_t               box_min_y   = '0;
  coord_t               box_min_z   = '0;
  coord_t               box_max_x   = '0;
  coord_t               box_max_y   = '0;
  coord_t               box_max_z   = '0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic                 visible;

  // local copy of the plane table and camera
  norm_t  plane_a [NUM_PLANES];
  norm_t  plane_b [NUM_PLANES];
  norm_t  plane_c [NUM_PLANES];
  coord_t plane_d [NUM_PLANES];
  coord_t cam_x = '0;
  coord_t cam_y = '0;
  coord_t cam_z = '0;

  cull_beat_t beats_to_send[$];
  logic       verdicts_due[$];
  cull_beat_t cur_beat;
  int         beats_queued = 0;
  int         beats_taken  = 0;
  int         gap_left     = 0;
  int         stall_left   = 0;
  int         errors       = 0;
  int         cycles       = 0;
  bit         tx_idle      = 1'b1;
  bit         rx_idle      = 1'b1;

  frustum_box_cull_top i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : table_clear
    int p;
    for (p = 0; p < NUM_PLANES; p++) begin
      plane_a[p] = '0;
      plane_b[p] = '0;
      plane_c[p] = '0;
      plane_d[p] = '0;
    end
  end

  function automatic longint axis_term(norm_t n, coord_t lo, coord_t hi, coord_t cam);
    longint nn;
    longint corner;
    nn     = n;
    corner = (nn > 0) ? longint'(hi) : longint'(lo);
    return nn * (corner - longint'(cam));
  endfunction

  function automatic logic box_visible(cull_beat_t b);
    longint s;
    int     p;
    for (p = 0; p < NUM_PLANES; p++) begin
      s = axis_term(plane_a[p], b.min_x, b.max_x, cam_x)
        + axis_term(plane_b[p], b.min_y, b.max_y, cam_y)
        + axis_term(plane_c[p], b.min_z, b.max_z, cam_z)
        + longint'(plane_d[p]) * 65536;
      if (s < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void take_beat(cull_beat_t b);
    if (b.act == ACT_WRITE) begin
      if (b.idx < NUM_PLANES) begin
        plane_a[b.idx] = b.na;
        plane_b[b.idx] = b.nb;
        plane_c[b.idx] = b.nc;
        plane_d[b.idx] = b.d;
      end
    end else begin
      verdicts_due.push_back(box_visible(b));
    end
  endfunction

  function automatic int draw_wait(bit on);
    if (!on || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic flag_mismatch(string msg);
    if (errors < 30) $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic coord_t pick_coord(int span);
    coord_t v;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0:       return CMIN;
        1:       return CMAX;
        default: return '0;
      endcase
    end
    v = $urandom;
    return v >>> (31 - span);
  endfunction

  function automatic norm_t pick_norm();
    norm_t v;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = NMIN;
      2:       v = NMAX;
      default: v = norm_t'($urandom_range(0, 262143));
    endcase
    return v;
  endfunction

  function automatic cull_beat_t random_beat();
    cull_beat_t b;
    b.act   = 1'($urandom_range(0, 1));
    b.idx   = 3'($urandom_range(0, 7));
    b.na    = norm_t'($urandom);
    b.nb    = norm_t'($urandom);
    b.nc    = norm_t'($urandom);
    b.d     = $urandom;
    b.min_x = $urandom;
    b.min_y = $urandom;
    b.min_z = $urandom;
    b.max_x = $urandom;
    b.max_y = $urandom;
    b.max_z = $urandom;
    return b;
  endfunction

  function automatic void enqueue_beat(cull_beat_t b);
    beats_to_send.push_back(b);
    beats_queued++;
  endfunction

  function automatic void push_plane(logic [2:0] idx, norm_t a, norm_t b, norm_t c, coord_t d);
    cull_beat_t w;
    w     = random_beat();
    w.act = ACT_WRITE;
    w.idx = idx;
    w.na  = a;
    w.nb  = b;
    w.nc  = c;
    w.d   = d;
    enqueue_beat(w);
  endfunction

  function automatic void push_box(coord_t lx, coord_t ly, coord_t lz,
                                   coord_t hx, coord_t hy, coord_t hz);
    cull_beat_t t;
    t       = random_beat();
    t.act   = ACT_TEST;
    t.min_x = lx;
    t.min_y = ly;
    t.min_z = lz;
    t.max_x = hx;
    t.max_y = hy;
    t.max_z = hz;
    enqueue_beat(t);
  endfunction

  function automatic void push_random_box(int span);
    coord_t lo [3];
    coord_t hi [3];
    coord_t p;
    coord_t q;
    int     shape;
    int     ax;
    shape = $urandom_range(0, 3);
    for (ax = 0; ax < 3; ax++) begin
      p = pick_coord(span);
      q = pick_coord(span);
      case (shape)
        0: begin
          lo[ax] = p;
          hi[ax] = q;
        end
        1: begin
          lo[ax] = (p < q) ? p : q;
          hi[ax] = (p < q) ? q : p;
        end
        2: begin
          lo[ax] = CMIN >>> (31 - span);
          hi[ax] = CMAX >>> (31 - span);
        end
        default: begin
          lo[ax] = (p < q) ? q : p;
          hi[ax] = (p < q) ? p : q;
        end
      endcase
    end
    push_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CAMERA_X: cam_x = val;
      REG_CAMERA_Y: cam_y = val;
      REG_CAMERA_Z: cam_z = val;
      default: ;
    endcase
  endtask

  task automatic settle();
    do @(posedge clk); while (beats_taken != beats_queued || verdicts_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        take_beat(cur_beat);
        beats_taken++;
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (beats_to_send.size() > 0) begin
        cur_beat    = beats_to_send.pop_front();
        action      <= cur_beat.act;
        plane_index <= cur_beat.idx;
        normal_a    <= cur_beat.na;
        normal_b    <= cur_beat.nb;
        normal_c    <= cur_beat.nc;
        offset_d    <= cur_beat.d;
        box_min_x   <= cur_beat.min_x;
        box_min_y   <= cur_beat.min_y;
        box_min_z   <= cur_beat.min_z;
        box_max_x   <= cur_beat.max_x;
        box_max_y   <= cur_beat.max_y;
        box_max_z   <= cur_beat.max_z;
        in_valid    <= 1'b1;
        gap_left    <= draw_wait(tx_idle);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    int   nxt;
    logic want;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      nxt = (stall_left > 0) ? stall_left - 1 : 0;
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          flag_mismatch("result beat with no box test waiting");
        end else begin
          want = verdicts_due.pop_front();
          if (visible !== want)
            flag_mismatch($sformatf("visible %b, expected %b", visible, want));
        end
        nxt = draw_wait(rx_idle);
      end
      stall_left <= nxt;
      out_ready  <= (nxt == 0);
    end
  end

  initial begin : stimulus
    int     phase;
    int     items;
    int     n;
    int     span;
    coord_t cx;
    coord_t cy;
    coord_t cz;
    cull_beat_t b;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // unloaded table: everything visible
    push_box(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    push_box(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    push_box(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
    // out-of-range plane writes are dropped
    push_plane(3'd6, NMIN, NMIN, NMIN, CMIN);
    push_plane(3'd7, NMAX, NMIN, NMAX, CMIN);
    push_box('0, '0, '0, '0, '0, '0);
    push_plane(3'd0, NMAX, '0, '0, '0);
    push_box(-32'sd5, '0, '0, -32'sd1, '0, '0);
    push_box(-32'sd5, '0, '0, '0, '0, '0);
    push_box(32'sd100, '0, '0, -32'sd100, '0, '0);
    push_plane(3'd1, NMIN, NMIN, NMIN, CMAX);
    push_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    push_plane(3'd2, '0, '0, '0, -32'sd1);
    push_box('0, '0, '0, CMAX, CMAX, CMAX);
    push_plane(3'd2, '0, '0, '0, '0);
    push_plane(3'd3, '0, NMAX, '0, CMIN);
    push_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    push_box(CMIN, CMIN, CMIN, CMAX, 32'sh4000_0000, CMAX);
    push_plane(3'd4, '0, '0, NMIN, '0);
    push_box(CMIN, CMIN, '0, CMAX, CMAX, CMAX);
    push_box(CMIN, CMIN, 32'sd1, CMAX, CMAX, CMAX);
    push_plane(3'd5, NMAX, NMAX, NMAX, CMAX);
    push_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    settle();

    for (phase = 0; phase < PHASES; phase++) begin
      tx_idle = (phase % 3 != 2);
      rx_idle = (phase % 4 != 1);
      case (phase)
        0: begin
          cx = CMIN;
          cy = CMAX;
          cz = '0;
        end
        1: begin
          cx = CMAX;
          cy = CMAX;
          cz = CMAX;
        end
        2: begin
          cx = CMIN;
          cy = CMIN;
          cz = CMIN;
        end
        default: begin
          span = ($urandom_range(0, 1) != 0) ? 31 : 20;
          cx = pick_coord(span);
          cy = pick_coord(span);
          cz = pick_coord(span);
        end
      endcase
      cfg_write(REG_CAMERA_X, cx);
      cfg_write(REG_CAMERA_Y, cy);
      cfg_write(REG_CAMERA_Z, cz);
      if (phase == 0) cfg_write(REG_SPARE, $urandom);
      cfg_valid <= 1'b0;

      items = 0;
      while (items < PHASE_ITEMS) begin
        span = ($urandom_range(0, 1) != 0) ? 31 : 20;
        if ($urandom_range(0, 5) == 0) begin
          if ($urandom_range(0, 1) != 0) begin
            push_plane(3'($urandom_range(6, 7)), pick_norm(), pick_norm(), pick_norm(),
                       pick_coord(31));
          end else begin
            b     = random_beat();
            b.act = ACT_TEST;
            enqueue_beat(b);
            items++;
          end
        end else begin
          n = $urandom_range(1, 6);
          items += n;
          repeat (n)
            push_plane(3'($urandom_range(0, NUM_PLANES - 1)), pick_norm(), pick_norm(),
                       pick_norm(), pick_coord(span));
          n = $urandom_range(1, 8);
          items += n;
          repeat (n) push_random_box(span);
        end
      end
      settle();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/fbc_pkg.sv
src/fbc_ctrl.sv
src/fbc_dp.sv
src/frustum_box_cull_top.sv
verif/tb_frustum_box_cull_top.sv
